>>> design/zsr_pkg.sv
package zsr_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int AMOUNT_BITS   = 32;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
  localparam int EPOCH_BITS    = 4;

  localparam logic [63:0] HASH_MUL  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] FREQ_MAX  = 32'hFFFF_FFFF;
  localparam logic [62:0] TOTAL_MAX = {63{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_STALE = '0;
  localparam logic [SLOT_BITS-1:0]  LAST_SLOT   = SLOT_BITS'(TABLE_ENTRIES - 1);
  // home slot of prefix zero
  localparam logic [SLOT_BITS-1:0]  ZERO_HOME   = '0;

  typedef struct packed {
    logic signed [31:0] amount;
    logic               last_item;
  } zsr_in_t;

  typedef struct packed {
    logic [31:0] matches_now;
    logic [62:0] zero_range_total;
    logic        table_full;
    logic        end_of_sequence;
  } zsr_out_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [63:0]           key;
    logic [31:0]           freq;
  } zsr_entry_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
    zsr_entry_t           entry;
  } zsr_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_HASH,
    ST_PROBE,
    ST_UPD
  } zsr_state_t;

  typedef enum logic [1:0] {
    OC_HIT,
    OC_FREE,
    OC_FULL
  } zsr_outcome_t;

endpackage

>>> design/zsr_hash.sv
module zsr_hash (
  input  logic                       clk,
  input  logic [63:0]                key,
  output logic [zsr_pkg::SLOT_BITS-1:0] slot
);
  import zsr_pkg::*;

  logic [63:0]          prod_lo_r;
  logic [SLOT_BITS-1:0] cross_a_r;
  logic [SLOT_BITS-1:0] cross_b_r;
  logic [2*SLOT_BITS-1:0] cross_a;
  logic [2*SLOT_BITS-1:0] cross_b;

  // bits [32 +: SLOT_BITS] of key * HASH_MUL mod 2^64, split into narrow products
  assign cross_a = key[SLOT_BITS-1:0] * HASH_MUL[32 +: SLOT_BITS];
  assign cross_b = key[32 +: SLOT_BITS] * HASH_MUL[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    prod_lo_r <= key[31:0] * HASH_MUL[31:0];
    cross_a_r <= cross_a[SLOT_BITS-1:0];
    cross_b_r <= cross_b[SLOT_BITS-1:0];
  end

  assign slot = prod_lo_r[32 +: SLOT_BITS] + cross_a_r + cross_b_r;

endmodule

>>> design/zsr_table.sv
module zsr_table (
  input  logic                          clk,
  input  zsr_pkg::zsr_wr_t              wr,
  input  logic [zsr_pkg::SLOT_BITS-1:0] rd_addr,
  output zsr_pkg::zsr_entry_t           rd_data
);
  import zsr_pkg::*;

  zsr_entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/zero_sum_range_counter_unit.sv
// Zero-sum range counter.
// Input channel in_valid/in_ready/in_data carries one amount per request,
// with last_item closing a sequence. Output channel out_valid/out_ready/
// out_data returns exactly one result per request, in order.
// One request is in flight at a time. After acceptance the request passes
// ST_MUL, ST_HASH, ST_PROBE and ST_UPD; the probe state repeats once per
// extra slot of the linear probe run (at most TABLE_ENTRIES - 1), and the
// next request is taken in ST_IDLE once ST_UPD is left.
// The probe loop over the table memory reads one slot per cycle; the hash
// is a registered multiply followed by a combinational add.
// After the last item of a sequence ST_INIT re-seeds the prefix-zero
// entry; table entries of older sequences are retired by an epoch tag.
// Reset (and every 15th sequence end, when the tag wraps) runs a clearing
// pass over every table entry, during which in_ready stays low.
// The result sits in an output register; while the receiver stalls, the
// next request is still accepted and processed up to its table update,
// which waits until the output register is free.
module zero_sum_range_counter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  zsr_pkg::zsr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output zsr_pkg::zsr_out_t out_data
);
  import zsr_pkg::*;

  zsr_state_t            state_r, state_nxt;
  zsr_outcome_t          outcome_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic [SLOT_BITS-1:0]  clr_r;
  logic [SLOT_BITS-1:0]  slot_r;
  logic [SLOT_BITS-1:0]  cnt_r;
  logic [63:0]           prefix_r;
  logic [62:0]           total_r;
  logic [63:0]           key_r;
  logic [31:0]           freq_r;
  logic                  last_r;
  logic                  out_valid_r;
  zsr_out_t              out_data_r;

  logic [SLOT_BITS-1:0]  hash_slot;
  logic [SLOT_BITS-1:0]  slot_next;
  logic [SLOT_BITS-1:0]  rd_addr;
  zsr_entry_t            rd_data;
  zsr_wr_t               wr;
  logic                  out_free;
  logic                  live;
  logic                  hit;
  logic [63:0]           amt_ext;
  logic [63:0]           total_sum;
  logic [62:0]           total_nxt;
  logic [31:0]           freq_inc;

  zsr_hash u_hash (
    .clk  (clk),
    .key  (key_r),
    .slot (hash_slot)
  );

  zsr_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign amt_ext   = {{(64-AMOUNT_BITS){in_data.amount[AMOUNT_BITS-1]}},
                      in_data.amount[AMOUNT_BITS-1:0]};
  assign out_free  = !out_valid_r || out_ready;
  assign live      = (rd_data.tag == epoch_r);
  assign hit       = live && (rd_data.key == key_r);
  assign slot_next = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign total_sum = {1'b0, total_r} + {32'd0, freq_r};
  assign total_nxt = total_sum[63] ? TOTAL_MAX : total_sum[62:0];
  assign freq_inc  = (freq_r == FREQ_MAX) ? freq_r : freq_r + 32'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST_SLOT) state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_HASH;
      ST_HASH:  state_nxt = ST_PROBE;
      ST_PROBE: if (!live || hit || cnt_r == LAST_SLOT) state_nxt = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          if (!last_r)                 state_nxt = ST_IDLE;
          else if (epoch_r == EPOCH_MAX) state_nxt = ST_CLEAR;
          else                         state_nxt = ST_INIT;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_addr  = slot_r;
    wr       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr.en        = 1'b1;
        wr.addr      = clr_r;
        wr.entry.tag = EPOCH_STALE;
      end
      ST_INIT: begin
        wr.en         = 1'b1;
        wr.addr       = ZERO_HOME;
        wr.entry.tag  = epoch_r;
        wr.entry.freq = 32'd1;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_MUL:   ;
      ST_HASH:  rd_addr = hash_slot;
      ST_PROBE: rd_addr = slot_next;
      ST_UPD: begin
        wr.addr      = slot_r;
        wr.entry.tag = epoch_r;
        wr.entry.key = key_r;
        if (outcome_r == OC_HIT) begin
          wr.en         = out_free;
          wr.entry.freq = freq_inc;
        end else if (outcome_r == OC_FREE) begin
          wr.en         = out_free;
          wr.entry.freq = 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      epoch_r     <= EPOCH_FIRST;
      prefix_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      outcome_r   <= OC_FULL;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_SLOT) epoch_r <= EPOCH_FIRST;
        end
        ST_IDLE: begin
          if (in_valid) begin
            key_r    <= prefix_r + amt_ext;
            prefix_r <= prefix_r + amt_ext;
            last_r   <= in_data.last_item;
          end
        end
        ST_HASH: begin
          slot_r <= hash_slot;
          cnt_r  <= '0;
        end
        ST_PROBE: begin
          freq_r <= rd_data.freq;
          if (hit) begin
            outcome_r <= OC_HIT;
          end else if (!live) begin
            outcome_r <= OC_FREE;
          end else begin
            outcome_r <= OC_FULL;
            slot_r    <= slot_next;
            cnt_r     <= cnt_r + 1'b1;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            out_data_r.matches_now      <= (outcome_r == OC_HIT) ? freq_r : 32'd0;
            out_data_r.zero_range_total <= (outcome_r == OC_HIT) ? total_nxt : total_r;
            out_data_r.table_full       <= (outcome_r == OC_FULL);
            out_data_r.end_of_sequence  <= last_r;
            if (last_r) begin
              prefix_r <= '0;
              total_r  <= '0;
              clr_r    <= '0;
              if (epoch_r != EPOCH_MAX) epoch_r <= epoch_r + 1'b1;
            end else if (outcome_r == OC_HIT) begin
              total_r <= total_nxt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/zsr_checker.sv
module zsr_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  zsr_pkg::zsr_out_t out_data
);
  import zsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> out_data.matches_now == 32'd0)
    else $error("matches reported on full table");

  a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.matches_now != 32'd0 |-> out_data.zero_range_total != 63'd0)
    else $error("total below matches");

endmodule

bind zero_sum_range_counter_unit zsr_checker u_zsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import zsr_pkg::*;

  localparam logic signed [31:0] AMOUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] AMOUNT_MIN = 32'sh8000_0000;
  localparam int RANDOM_REQUESTS = 600;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  zsr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  zsr_out_t out_data;

  zero_sum_range_counter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // prefix-sum table mirror
  logic [63:0] prefix_sum;
  logic [62:0] range_total;
  logic [63:0] slot_key   [TABLE_ENTRIES];
  logic [31:0] slot_count [TABLE_ENTRIES];
  bit          slot_live  [TABLE_ENTRIES];

  zsr_out_t    expected_counts[$];
  int unsigned error_count = 0;
  bit          in_gaps_on = 1'b0;
  bit          out_stalls_on = 1'b0;
  int unsigned stall_left = 0;

  function automatic int unsigned home_slot_of(logic [63:0] key);
    logic [63:0] product;
    product = key * HASH_MUL;
    return int'((product >> 32) % TABLE_ENTRIES);
  endfunction

  function automatic void restart_sequence();
    int unsigned s;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_live[i] = 1'b0;
    end
    prefix_sum = '0;
    range_total = '0;
    s = home_slot_of(64'd0);
    slot_key[s] = '0;
    slot_count[s] = 32'd1;
    slot_live[s] = 1'b1;
  endfunction

  function automatic void count_zero_ranges(zsr_in_t req);
    logic [63:0] amount_ext;
    int unsigned slot;
    bit          found;
    zsr_out_t    res;
    amount_ext = {{32{req.amount[31]}}, req.amount};
    prefix_sum = prefix_sum + amount_ext;
    res = '0;
    slot = home_slot_of(prefix_sum);
    found = 1'b0;
    for (int n = 0; n < TABLE_ENTRIES && !found; n++) begin
      if (!slot_live[slot] || slot_key[slot] == prefix_sum) begin
        found = 1'b1;
      end else begin
        slot = (slot + 1) % TABLE_ENTRIES;
      end
    end
    if (!found) begin
      res.table_full = 1'b1;
    end else if (slot_live[slot]) begin
      res.matches_now = slot_count[slot];
      if (TOTAL_MAX - range_total < 63'(slot_count[slot])) begin
        range_total = TOTAL_MAX;
      end else begin
        range_total = range_total + 63'(slot_count[slot]);
      end
      if (slot_count[slot] != FREQ_MAX) begin
        slot_count[slot] = slot_count[slot] + 32'd1;
      end
    end else begin
      slot_key[slot] = prefix_sum;
      slot_count[slot] = 32'd1;
      slot_live[slot] = 1'b1;
    end
    res.zero_range_total = range_total;
    res.end_of_sequence = req.last_item;
    expected_counts.push_back(res);
    if (req.last_item) begin
      restart_sequence();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 8) begin
      return 0;
    end else if (r < 14) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    zsr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("result with no request pending: %p", out_data);
        end
      end else begin
        want = expected_counts.pop_front();
        if (out_data.matches_now !== want.matches_now) begin
          note_mismatch("matches_now", 64'(want.matches_now), 64'(out_data.matches_now));
        end
        if (out_data.zero_range_total !== want.zero_range_total) begin
          note_mismatch("zero_range_total", 64'(want.zero_range_total),
                        64'(out_data.zero_range_total));
        end
        if (out_data.table_full !== want.table_full) begin
          note_mismatch("table_full", 64'(want.table_full), 64'(out_data.table_full));
        end
        if (out_data.end_of_sequence !== want.end_of_sequence) begin
          note_mismatch("end_of_sequence", 64'(want.end_of_sequence),
                        64'(out_data.end_of_sequence));
        end
      end
    end
  end

  task automatic send_request(logic signed [31:0] amount, bit last);
    zsr_in_t     req;
    int unsigned gap;
    req.amount = amount;
    req.last_item = last;
    gap = in_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    count_zero_ranges(req);
  endtask

  task automatic test_directed();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    send_request(0, 1'b0);
    send_request(0, 1'b0);
    send_request(0, 1'b1);
    send_request(AMOUNT_MAX, 1'b0);
    send_request(AMOUNT_MIN, 1'b0);
    send_request(1, 1'b0);
    send_request(AMOUNT_MIN, 1'b0);
    send_request(AMOUNT_MAX, 1'b0);
    send_request(1, 1'b0);
    send_request(-1, 1'b0);
    send_request(-1, 1'b0);
    send_request(AMOUNT_MAX, 1'b0);
    send_request(AMOUNT_MAX, 1'b0);
    send_request(AMOUNT_MIN, 1'b0);
    send_request(AMOUNT_MIN, 1'b1);
    send_request(5, 1'b1);
    send_request(-5, 1'b1);
    send_request(-1, 1'b0);
    send_request(1, 1'b1);
  endtask

  task automatic test_table_full();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    // prefixes 1 .. N-1 plus the zero entry occupy every slot
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      send_request(1, 1'b0);
    end
    send_request(1, 1'b0);
    send_request(-1, 1'b0);
    send_request(2, 1'b0);
    send_request(32'(-(TABLE_ENTRIES + 1)), 1'b1);
  endtask

  task automatic test_random_sequences();
    logic signed [31:0] vals[$];
    int unsigned        kind;
    int                 len;
    int                 sent;
    bit                 last;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      in_gaps_on = !(sent >= 200 && sent < 320);
      out_stalls_on = in_gaps_on;
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
      vals = {};
      for (int i = 0; i < len; i++) begin
        case (kind)
          5, 6, 8, 9: vals.push_back($urandom);
          7: begin
            case ($urandom_range(0, 3))
              0: vals.push_back(AMOUNT_MAX);
              1: vals.push_back(AMOUNT_MIN);
              2: vals.push_back(-1);
              default: vals.push_back(1);
            endcase
          end
          default: vals.push_back(32'(int'($urandom_range(0, 6)) - 3));
        endcase
      end
      // mirrored tail walks the prefix back through the same values
      if (kind == 5 || kind == 6) begin
        for (int i = len - 1; i >= 0; i--) begin
          vals.push_back(-vals[i]);
        end
      end
      for (int i = 0; i < vals.size(); i++) begin
        if (kind >= 8) begin
          last = ($urandom_range(0, 5) == 0);
        end else begin
          last = (i == vals.size() - 1);
        end
        send_request(vals[i], last);
        sent++;
      end
    end
  endtask

  initial begin
    restart_sequence();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random_sequences();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 16) @(posedge clk);
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
